// ----- rtl/core/dcfp_pkg.sv -----
`timescale 1ns / 1ps

package dcfp_pkg;

	// frame bytes
	localparam logic [7:0] HDR_S    = 8'h53;
	localparam logic [7:0] HDR_T    = 8'h54;
	localparam logic [7:0] HDR_X    = 8'h58;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_LF  = 8'h0A;

	localparam int PAY_BYTES = 8;
	localparam int LIM_W     = 15;
	localparam int MODE_W    = 2;
	localparam int VAL_W     = 16;

	// payload byte positions
	localparam int P_AUTO  = 0;
	localparam int P_STOP  = 1;
	localparam int P_MODE  = 2;
	localparam int P_SPDL  = 3;
	localparam int P_SPDH  = 4;
	localparam int P_STRL  = 5;
	localparam int P_STRH  = 6;
	localparam int P_ALIVE = 7;

	// highest valid mode byte
	localparam logic [7:0] MODE_MAX = 8'd2;

	// config register indexes
	localparam logic [2:0] REG_SPEED_LIM = 3'd0;
	localparam logic [2:0] REG_STEER_4WS = 3'd1;
	localparam logic [2:0] REG_STEER_OTH = 3'd2;
	localparam logic [2:0] REG_FALLBACK  = 3'd3;
	localparam logic [2:0] REG_4WS_CODE  = 3'd4;

	localparam logic [LIM_W-1:0]  RST_SPEED_LIM = 15'd300;
	localparam logic [LIM_W-1:0]  RST_STEER_4WS = 15'd18;
	localparam logic [LIM_W-1:0]  RST_STEER_OTH = 15'd30;
	localparam logic [MODE_W-1:0] RST_FALLBACK  = 2'd0;
	localparam logic [MODE_W-1:0] RST_4WS_CODE  = 2'd1;

	typedef enum logic [3:0] {
		PH_HUNT_S = 4'd0,
		PH_HUNT_T = 4'd1,
		PH_HUNT_X = 4'd2,
		PH_PAY0   = 4'd3,
		PH_PAY1   = 4'd4,
		PH_PAY2   = 4'd5,
		PH_PAY3   = 4'd6,
		PH_PAY4   = 4'd7,
		PH_PAY5   = 4'd8,
		PH_PAY6   = 4'd9,
		PH_PAY7   = 4'd10,
		PH_CR     = 4'd11,
		PH_LF     = 4'd12
	} phase_t;

	typedef struct packed {
		logic [LIM_W-1:0]  speed_lim;
		logic [LIM_W-1:0]  steer_lim_4ws;
		logic [LIM_W-1:0]  steer_lim_oth;
		logic [MODE_W-1:0] fallback;
		logic [MODE_W-1:0] code_4ws;
	} cfg_t;

	// framer status toward the top level
	typedef struct packed {
		logic                           done;
		logic [PAY_BYTES-1:0][7:0]      bytes;
	} frame_t;

	typedef struct packed {
		logic              auto_flag;
		logic              stop_flag;
		logic [MODE_W-1:0] drive_mode;
		logic [VAL_W-1:0]  speed_centi;
		logic [VAL_W-1:0]  steer_angle;
		logic [7:0]        alive_count;
	} cmd_t;

endpackage

// ----- rtl/core/dcfp_framer.sv -----
`timescale 1ns / 1ps

module dcfp_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output dcfp_pkg::frame_t    frame
);

	dcfp_pkg::phase_t phase_q, phase_nxt;
	logic [dcfp_pkg::PAY_BYTES-1:0][7:0] pay_q;
	logic       store_en;
	logic [2:0] store_idx;
	logic       done;

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			dcfp_pkg::PH_HUNT_S: phase_nxt = (rx_byte == dcfp_pkg::HDR_S) ?
				dcfp_pkg::PH_HUNT_T : dcfp_pkg::PH_HUNT_S;
			dcfp_pkg::PH_HUNT_T: phase_nxt = (rx_byte == dcfp_pkg::HDR_T) ?
				dcfp_pkg::PH_HUNT_X : dcfp_pkg::PH_HUNT_S;
			dcfp_pkg::PH_HUNT_X: phase_nxt = (rx_byte == dcfp_pkg::HDR_X) ?
				dcfp_pkg::PH_PAY0 : dcfp_pkg::PH_HUNT_S;
			dcfp_pkg::PH_PAY0, dcfp_pkg::PH_PAY1, dcfp_pkg::PH_PAY2,
			dcfp_pkg::PH_PAY3, dcfp_pkg::PH_PAY4, dcfp_pkg::PH_PAY5,
			dcfp_pkg::PH_PAY6, dcfp_pkg::PH_PAY7:
				phase_nxt = dcfp_pkg::phase_t'(phase_q + 4'd1);
			dcfp_pkg::PH_CR: phase_nxt = (rx_byte == dcfp_pkg::BYTE_CR) ?
				dcfp_pkg::PH_LF : dcfp_pkg::PH_HUNT_S;
			dcfp_pkg::PH_LF: phase_nxt = dcfp_pkg::PH_HUNT_S;
			default: phase_nxt = dcfp_pkg::PH_HUNT_S;
		endcase
	end

	// outputs
	always_comb begin
		store_en  = 1'b0;
		store_idx = 3'(phase_q - dcfp_pkg::PH_PAY0);
		done      = 1'b0;
		case (phase_q)
			dcfp_pkg::PH_PAY0, dcfp_pkg::PH_PAY1, dcfp_pkg::PH_PAY2,
			dcfp_pkg::PH_PAY3, dcfp_pkg::PH_PAY4, dcfp_pkg::PH_PAY5,
			dcfp_pkg::PH_PAY6, dcfp_pkg::PH_PAY7:
				store_en = step;
			dcfp_pkg::PH_LF: done = step && (rx_byte == dcfp_pkg::BYTE_LF);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dcfp_pkg::PH_HUNT_S;
		end else if (step) begin
			phase_q <= phase_nxt;
		end
	end

	// payload store, no reset: every byte is written before a frame completes
	always_ff @(posedge clk) begin
		if (store_en) begin
			pay_q[store_idx] <= rx_byte;
		end
	end

	assign frame.done  = done;
	assign frame.bytes = pay_q;

endmodule

// ----- rtl/core/dcfp_decode.sv -----
`timescale 1ns / 1ps

module dcfp_decode (
	input  logic [dcfp_pkg::PAY_BYTES-1:0][7:0] bytes,
	input  dcfp_pkg::cfg_t                      cfg,
	output dcfp_pkg::cmd_t                      cmd
);

	logic [dcfp_pkg::MODE_W-1:0] mode;
	logic [dcfp_pkg::LIM_W-1:0]  steer_lim;
	logic signed [dcfp_pkg::VAL_W:0] spd_raw, str_raw;
	logic signed [dcfp_pkg::VAL_W:0] spd_lim, str_lim;

	always_comb begin
		mode = (bytes[dcfp_pkg::P_MODE] <= dcfp_pkg::MODE_MAX) ?
			bytes[dcfp_pkg::P_MODE][dcfp_pkg::MODE_W-1:0] : cfg.fallback;
		steer_lim = (mode == cfg.code_4ws) ? cfg.steer_lim_4ws : cfg.steer_lim_oth;

		// sign-extend to 17 bits so +-limit compares cleanly
		spd_raw = {bytes[dcfp_pkg::P_SPDH][7], bytes[dcfp_pkg::P_SPDH],
			bytes[dcfp_pkg::P_SPDL]};
		str_raw = {bytes[dcfp_pkg::P_STRH][7], bytes[dcfp_pkg::P_STRH],
			bytes[dcfp_pkg::P_STRL]};
		spd_lim = {2'b00, cfg.speed_lim};
		str_lim = {2'b00, steer_lim};

		cmd.auto_flag   = |bytes[dcfp_pkg::P_AUTO];
		cmd.stop_flag   = |bytes[dcfp_pkg::P_STOP];
		cmd.drive_mode  = mode;
		cmd.alive_count = bytes[dcfp_pkg::P_ALIVE];

		if (spd_raw > spd_lim)
			cmd.speed_centi = spd_lim[dcfp_pkg::VAL_W-1:0];
		else if (spd_raw < -spd_lim)
			cmd.speed_centi = 16'(-spd_lim);
		else
			cmd.speed_centi = spd_raw[dcfp_pkg::VAL_W-1:0];

		if (str_raw > str_lim)
			cmd.steer_angle = str_lim[dcfp_pkg::VAL_W-1:0];
		else if (str_raw < -str_lim)
			cmd.steer_angle = 16'(-str_lim);
		else
			cmd.steer_angle = str_raw[dcfp_pkg::VAL_W-1:0];
	end

endmodule

// ----- rtl/core/drive_command_frame_parser_core.sv -----
`timescale 1ns / 1ps

// Drive command frame parser. Takes one received byte per request on the s_ side
// and hunts for the header "STX", eight payload bytes (auto, estop, mode, speed
// lo/hi, steer lo/hi, alive) and a CR LF trailer; a bad header or trailer byte
// drops back to hunting. Each good frame yields one command request on the m_
// side: flags as 0/1, mode (above two replaced by the fallback register),
// speed and steer clamped to +-limit, steer limit picked by four-wheel mode.
// Rate: one byte per clock while the input register is not stalled. A byte sits
// in the input register while the phase machine steps and the payload store is
// written; the command for a frame is built combinationally from the stored
// payload and lands in the output register, so m_tvalid rises at the edge at
// which the LF byte leaves the input register. The input register only stalls
// when the output register still holds a command that has not been taken. Config
// writes are expected only while the parser is idle.
module drive_command_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// command stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [0] auto_flag, [1] stop_flag, [3:2] drive_mode,
	                               // [19:4] speed_centi, [35:20] steer_angle,
	                               // [43:36] alive_count, [47:44] zero
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	dcfp_pkg::cfg_t   cfg_q;
	dcfp_pkg::frame_t frame;
	dcfp_pkg::cmd_t   cmd;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       go_s1;
	logic       out_valid_q;
	logic [43:0] out_data_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_lim     <= dcfp_pkg::RST_SPEED_LIM;
			cfg_q.steer_lim_4ws <= dcfp_pkg::RST_STEER_4WS;
			cfg_q.steer_lim_oth <= dcfp_pkg::RST_STEER_OTH;
			cfg_q.fallback      <= dcfp_pkg::RST_FALLBACK;
			cfg_q.code_4ws      <= dcfp_pkg::RST_4WS_CODE;
		end else if (cfg_we) begin
			case (cfg_index)
				dcfp_pkg::REG_SPEED_LIM: cfg_q.speed_lim     <= cfg_data;
				dcfp_pkg::REG_STEER_4WS: cfg_q.steer_lim_4ws <= cfg_data;
				dcfp_pkg::REG_STEER_OTH: cfg_q.steer_lim_oth <= cfg_data;
				dcfp_pkg::REG_FALLBACK:  cfg_q.fallback <= cfg_data[dcfp_pkg::MODE_W-1:0];
				dcfp_pkg::REG_4WS_CODE:  cfg_q.code_4ws <= cfg_data[dcfp_pkg::MODE_W-1:0];
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	// byte moves out of the input register once the output slot is free
	assign go_s1    = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	dcfp_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (go_s1),
		.rx_byte (byte_s1),
		.frame   (frame)
	);

	dcfp_decode u_decode (
		.bytes (frame.bytes),
		.cfg   (cfg_q),
		.cmd   (cmd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame.done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.done) begin
			out_data_q <= {cmd.alive_count, cmd.steer_angle, cmd.speed_centi,
				cmd.drive_mode, cmd.stop_flag, cmd.auto_flag};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_data_q};

	// a finished frame never lands on a command still waiting to be taken
	a_done_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |-> (!out_valid_q || m_tready))
		else $error("frame done while output slot busy");

	// a new command only appears after a byte stepped the parser
	a_cmd_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(go_s1))
		else $error("command without a parser step");

	// a held byte stays in the input register until it is processed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go_s1) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a byte");

endmodule

// ----- dv/tb_drive_command_frame_parser_core.sv -----
`timescale 1ns / 1ps

// Byte-stream testbench for the drive command frame parser.
// A sender task offers rx bytes on s_, a local parser mirror tracks the frame
// phase and payload and queues the decoded command for every good LF. A checker
// on the m_ side pops the oldest queued command for each accepted request and
// compares it field by field.
module tb_drive_command_frame_parser_core;

	typedef logic [7:0] payload_t [0:dcfp_pkg::PAY_BYTES-1];

	localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
	localparam int SETTLE_CYCLES = 4;    // input reg + output reg, with margin
	localparam int FRAME_LEN     = 13;   // STX + 8 payload + CR LF
	localparam int POS_CR        = 11;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;    // [0] auto_flag, [1] stop_flag, [3:2] drive_mode,
	                         // [19:4] speed_centi, [35:20] steer_angle,
	                         // [43:36] alive_count, [47:44] zero
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [14:0] cfg_data;

	drive_command_frame_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register mirror
	logic [dcfp_pkg::LIM_W-1:0]  lim_speed;
	logic [dcfp_pkg::LIM_W-1:0]  lim_four;
	logic [dcfp_pkg::LIM_W-1:0]  lim_other;
	logic [dcfp_pkg::MODE_W-1:0] fb_mode;
	logic [dcfp_pkg::MODE_W-1:0] four_code;

	// parser mirror
	dcfp_pkg::phase_t rx_phase;
	payload_t         rx_pay;
	dcfp_pkg::cmd_t   decoded_cmds[$];

	int src_idle_pct;
	int sink_stall_pct;
	int err_count;
	int bytes_sent;
	int cmds_seen;
	logic hold_active;
	event hold_go;

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------
	function automatic logic [dcfp_pkg::VAL_W-1:0] clamp_sym(
		logic [dcfp_pkg::VAL_W-1:0] raw, logic [dcfp_pkg::LIM_W-1:0] lim);
		int v;
		int l;
		v = int'($signed(raw));
		l = int'(lim);
		if (v > l)
			v = l;
		else if (v < -l)
			v = -l;
		return v[dcfp_pkg::VAL_W-1:0];
	endfunction

	function automatic dcfp_pkg::cmd_t decode_frame();
		dcfp_pkg::cmd_t c;
		logic [dcfp_pkg::LIM_W-1:0] steer_lim;
		c.auto_flag  = (rx_pay[dcfp_pkg::P_AUTO] != 8'h00);
		c.stop_flag  = (rx_pay[dcfp_pkg::P_STOP] != 8'h00);
		// mode above two falls back; fallback of three passes through as is
		c.drive_mode = (rx_pay[dcfp_pkg::P_MODE] <= dcfp_pkg::MODE_MAX) ?
			rx_pay[dcfp_pkg::P_MODE][dcfp_pkg::MODE_W-1:0] : fb_mode;
		// plain equality, so a code of three only hits when the fallback is three
		steer_lim    = (c.drive_mode == four_code) ? lim_four : lim_other;
		c.speed_centi = clamp_sym({rx_pay[dcfp_pkg::P_SPDH], rx_pay[dcfp_pkg::P_SPDL]},
			lim_speed);
		c.steer_angle = clamp_sym({rx_pay[dcfp_pkg::P_STRH], rx_pay[dcfp_pkg::P_STRL]},
			steer_lim);
		c.alive_count = rx_pay[dcfp_pkg::P_ALIVE];
		return c;
	endfunction

	// one accepted byte through the phase machine
	function automatic void parse_byte(logic [7:0] b);
		case (rx_phase)
			dcfp_pkg::PH_HUNT_S: rx_phase = (b == dcfp_pkg::HDR_S) ?
				dcfp_pkg::PH_HUNT_T : dcfp_pkg::PH_HUNT_S;
			// a wrong header byte is dropped, not retried as a new 'S'
			dcfp_pkg::PH_HUNT_T: rx_phase = (b == dcfp_pkg::HDR_T) ?
				dcfp_pkg::PH_HUNT_X : dcfp_pkg::PH_HUNT_S;
			dcfp_pkg::PH_HUNT_X: rx_phase = (b == dcfp_pkg::HDR_X) ?
				dcfp_pkg::PH_PAY0 : dcfp_pkg::PH_HUNT_S;
			dcfp_pkg::PH_CR: rx_phase = (b == dcfp_pkg::BYTE_CR) ?
				dcfp_pkg::PH_LF : dcfp_pkg::PH_HUNT_S;
			dcfp_pkg::PH_LF: begin
				rx_phase = dcfp_pkg::PH_HUNT_S;
				if (b == dcfp_pkg::BYTE_LF)
					decoded_cmds.push_back(decode_frame());
			end
			default: begin
				if (rx_phase >= dcfp_pkg::PH_PAY0 && rx_phase <= dcfp_pkg::PH_PAY7) begin
					rx_pay[int'(rx_phase) - int'(dcfp_pkg::PH_PAY0)] = b;
					rx_phase = dcfp_pkg::phase_t'(rx_phase + 1);
				end else begin
					rx_phase = dcfp_pkg::PH_HUNT_S;
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------
	// entered and left just after a falling edge
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		parse_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// bad_pos < 0 sends a clean frame, else that byte gets corrupted
	task automatic send_frame(input payload_t p, input int bad_pos);
		logic [7:0] fr [0:FRAME_LEN-1];
		int i;
		fr[0] = dcfp_pkg::HDR_S;
		fr[1] = dcfp_pkg::HDR_T;
		fr[2] = dcfp_pkg::HDR_X;
		for (i = 0; i < dcfp_pkg::PAY_BYTES; i++)
			fr[3 + i] = p[i];
		fr[POS_CR]     = dcfp_pkg::BYTE_CR;
		fr[POS_CR + 1] = dcfp_pkg::BYTE_LF;
		if (bad_pos >= 0)
			fr[bad_pos] = fr[bad_pos] ^ 8'($urandom_range(1, 255));
		for (i = 0; i < FRAME_LEN; i++)
			push_byte(fr[i]);
	endtask

	// cfg_we is cleared and left low before returning, so it never toggles twice in one step
	task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			dcfp_pkg::REG_SPEED_LIM: lim_speed = data;
			dcfp_pkg::REG_STEER_4WS: lim_four  = data;
			dcfp_pkg::REG_STEER_OTH: lim_other = data;
			dcfp_pkg::REG_FALLBACK:  fb_mode   = data[dcfp_pkg::MODE_W-1:0];
			dcfp_pkg::REG_4WS_CODE:  four_code = data[dcfp_pkg::MODE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// park the input, let every queued command drain, then let the pipe empty
	task automatic drain_idle();
		s_tvalid <= 1'b0;
		while (decoded_cmds.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic payload_t make_payload(logic [7:0] a, logic [7:0] st, logic [7:0] md,
	                                          logic [15:0] spd, logic [15:0] str,
	                                          logic [7:0] alive);
		payload_t p;
		p[dcfp_pkg::P_AUTO]  = a;
		p[dcfp_pkg::P_STOP]  = st;
		p[dcfp_pkg::P_MODE]  = md;
		p[dcfp_pkg::P_SPDL]  = spd[7:0];
		p[dcfp_pkg::P_SPDH]  = spd[15:8];
		p[dcfp_pkg::P_STRL]  = str[7:0];
		p[dcfp_pkg::P_STRH]  = str[15:8];
		p[dcfp_pkg::P_ALIVE] = alive;
		return p;
	endfunction

	function automatic logic [dcfp_pkg::LIM_W-1:0] pick_limit();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			2:       return dcfp_pkg::LIM_W'($urandom_range(1, 400));
			default: return dcfp_pkg::LIM_W'($urandom_range(32767));
		endcase
	endfunction

	// raw 16-bit values biased toward the clamp boundary and the extremes
	function automatic logic [15:0] pick_value(logic [dcfp_pkg::LIM_W-1:0] lim);
		int off;
		case ($urandom_range(3))
			0: return 16'($urandom_range(65535));
			1: begin
				off = int'(lim) + int'($urandom_range(4)) - 2;
				if ($urandom_range(1))
					off = -off;
				return off[15:0];
			end
			2: return 16'(int'($urandom_range(128)) - 64);
			default: begin
				case ($urandom_range(3))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	function automatic payload_t rand_payload();
		logic [7:0] md;
		case ($urandom_range(4))
			0:       md = 8'd0;
			1:       md = 8'd1;
			2:       md = 8'd2;
			3:       md = 8'd3;
			default: md = 8'($urandom_range(255));
		endcase
		return make_payload($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)),
		                    $urandom_range(1) ? 8'h00 : 8'($urandom_range(255)),
		                    md,
		                    pick_value(lim_speed),
		                    pick_value($urandom_range(1) ? lim_four : lim_other),
		                    8'($urandom_range(255)));
	endfunction

	task automatic randomize_regs();
		write_reg(dcfp_pkg::REG_SPEED_LIM, pick_limit());
		write_reg(dcfp_pkg::REG_STEER_4WS, pick_limit());
		write_reg(dcfp_pkg::REG_STEER_OTH, pick_limit());
		// upper data bits are junk for the 2-bit registers
		write_reg(dcfp_pkg::REG_FALLBACK, 15'($urandom_range(32767)));
		write_reg(dcfp_pkg::REG_4WS_CODE, 15'($urandom_range(32767)));
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// reset register values: clamp both ways, flag reduction, mode fallback
	task automatic test_defaults();
		send_frame(make_payload(8'hFF, 8'h00, 8'd1, 16'h7FFF, 16'h8000, 8'hFF), -1);
		send_frame(make_payload(8'h00, 8'h01, 8'd255, 16'h8000, 16'h7FFF, 8'h00), -1);
		send_frame(make_payload(8'h01, 8'h80, 8'd2, 16'd123, 16'hFFF6, 8'h5A), -1);
		drain_idle();
	endtask

	// header and trailer faults each drop the frame; a clean one follows
	task automatic test_framing_errors();
		payload_t p;
		p = make_payload(8'h01, 8'h01, 8'd0, 16'd50, 16'd5, 8'h11);
		push_byte(dcfp_pkg::HDR_S);       // doubled 'S': second one is not a new start
		send_frame(p, -1);
		send_frame(p, 0);
		send_frame(p, 1);
		send_frame(p, 2);
		send_frame(p, POS_CR);
		send_frame(p, POS_CR + 1);
		send_frame(p, -1);
		drain_idle();
	endtask

	task automatic test_register_corners();
		// fallback and four-wheel code both three: mode 3 picks the four-wheel limit
		write_reg(dcfp_pkg::REG_FALLBACK, 15'd3);
		write_reg(dcfp_pkg::REG_4WS_CODE, 15'd3);
		write_reg(dcfp_pkg::REG_STEER_4WS, 15'd5);
		write_reg(dcfp_pkg::REG_STEER_OTH, 15'd7);
		send_frame(make_payload(8'h00, 8'h00, 8'd9, 16'd10, 16'd100, 8'h01), -1);
		send_frame(make_payload(8'h00, 8'h00, 8'd3, 16'd10, 16'hFF00, 8'h02), -1);
		drain_idle();
		write_reg(dcfp_pkg::REG_4WS_CODE, 15'd0);
		send_frame(make_payload(8'h00, 8'h00, 8'd0, 16'd10, 16'd100, 8'h03), -1);
		drain_idle();
		// all limits zero
		write_reg(dcfp_pkg::REG_SPEED_LIM, 15'd0);
		write_reg(dcfp_pkg::REG_STEER_4WS, 15'd0);
		write_reg(dcfp_pkg::REG_STEER_OTH, 15'd0);
		send_frame(make_payload(8'h00, 8'h00, 8'd2, 16'h1234, 16'h8000, 8'h04), -1);
		drain_idle();
		// widest limits: most negative raw value lands on -limit
		write_reg(dcfp_pkg::REG_SPEED_LIM, 15'h7FFF);
		write_reg(dcfp_pkg::REG_STEER_OTH, 15'h7FFF);
		write_reg(dcfp_pkg::REG_4WS_CODE, 15'd1);
		send_frame(make_payload(8'h00, 8'h00, 8'd2, 16'h8000, 16'h7FFF, 8'h05), -1);
		drain_idle();
		// indexes past the last register must not disturb anything
		write_reg(3'(dcfp_pkg::REG_4WS_CODE + 1), 15'h7FFF);
		write_reg(3'(dcfp_pkg::REG_4WS_CODE + 2), 15'h0000);
		write_reg(3'(dcfp_pkg::REG_4WS_CODE + 3), 15'h5555);
		send_frame(make_payload(8'h00, 8'h00, 8'd7, 16'h8001, 16'h0123, 8'h06), -1);
		drain_idle();
	endtask

	// mostly clean frames with random content, some corrupted, some with noise ahead
	task automatic test_random_traffic(input int src_pct, input int sink_pct,
	                                   input int n_frames);
		int kind;
		int bad;
		payload_t p;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		randomize_regs();
		repeat (n_frames) begin
			kind = $urandom_range(9);
			if (kind == 9)
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
			if (kind == 7)
				bad = $urandom_range(2);
			else if (kind == 8)
				bad = POS_CR + $urandom_range(1);
			else
				bad = -1;
			p = rand_payload();
			send_frame(p, bad);
		end
		drain_idle();
	endtask

	// receiver holds off while the sender keeps pushing: the block fills and stalls s_
	task automatic test_backpressure();
		payload_t p;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		-> hold_go;
		repeat (4) begin
			p = rand_payload();
			send_frame(p, -1);
		end
		drain_idle();
	endtask

	// ---------------------------------------------------------------
	// receiver side
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_active)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// hold-off counter lives in its own process
	initial begin
		hold_active = 1'b0;
		forever begin
			@(hold_go);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_active <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
	                           input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	// every accepted command request is matched against the oldest decoded one
	always @(posedge clk) begin : cmd_check
		dcfp_pkg::cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_cmds.size() == 0) begin
				$display("%0t: command not expected, expected none, got %h", $time, m_tdata);
				err_count++;
			end else begin
				want = decoded_cmds.pop_front();
				check_field("auto_flag",   16'(want.auto_flag),   16'(m_tdata[0]));
				check_field("stop_flag",   16'(want.stop_flag),   16'(m_tdata[1]));
				check_field("drive_mode",  16'(want.drive_mode),  16'(m_tdata[3:2]));
				check_field("speed_centi", want.speed_centi,      m_tdata[19:4]);
				check_field("steer_angle", want.steer_angle,      m_tdata[35:20]);
				check_field("alive_count", 16'(want.alive_count), 16'(m_tdata[43:36]));
				check_field("pad bits",    16'h0000,              16'(m_tdata[47:44]));
			end
			cmds_seen++;
		end
	end

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'h00;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		lim_speed      = dcfp_pkg::RST_SPEED_LIM;
		lim_four       = dcfp_pkg::RST_STEER_4WS;
		lim_other      = dcfp_pkg::RST_STEER_OTH;
		fb_mode        = dcfp_pkg::RST_FALLBACK;
		four_code      = dcfp_pkg::RST_4WS_CODE;
		rx_phase       = dcfp_pkg::PH_HUNT_S;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		err_count      = 0;
		bytes_sent     = 0;
		cmds_seen      = 0;
		for (int i = 0; i < dcfp_pkg::PAY_BYTES; i++)
			rx_pay[i] = 8'h00;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_defaults();
		test_framing_errors();
		test_register_corners();
		// flow phases: free running, sparse sender, stalling receiver, both lightly
		test_random_traffic(0, 0, 3);
		test_random_traffic(0, 0, 3);
		test_random_traffic(84, 0, 3);
		test_random_traffic(84, 0, 3);
		test_random_traffic(0, 84, 3);
		test_random_traffic(0, 84, 3);
		test_random_traffic(11, 11, 3);
		test_random_traffic(11, 11, 3);
		test_backpressure();

		$display("Run sent %0d byte requests and checked %0d decoded commands,", bytes_sent,
		         cmds_seen);
		$display("over register corners, random settings, four flow mixes and a long hold-off.");
		if (err_count == 0)
			$display("** drive_command_frame_parser_core: PASSED **");
		else
			$display("** drive_command_frame_parser_core: FAILED **");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Timeout with %0d commands still outstanding", decoded_cmds.size());
		$display("** drive_command_frame_parser_core: FAILED **");
		$finish;
	end

endmodule
